// File: design/wdg_pkg.sv
// Shared constants, codes and types of the damped wave grid block.
`timescale 1ns / 1ps
package wdg_pkg;

  localparam int GRID_SIZE = 64;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] GAIN_RESET = 17'd26542;
  localparam logic [REG_W-1:0] DAMP_RESET = 17'd63898;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Datapath operations issued by the controller
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE  = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd2;
  localparam logic [OP_W-1:0] OP_RD    = 4'd3;
  localparam logic [OP_W-1:0] OP_EXEC  = 4'd4;
  localparam logic [OP_W-1:0] OP_C     = 4'd5;
  localparam logic [OP_W-1:0] OP_N     = 4'd6;
  localparam logic [OP_W-1:0] OP_S     = 4'd7;
  localparam logic [OP_W-1:0] OP_WEST  = 4'd8;
  localparam logic [OP_W-1:0] OP_EAST  = 4'd9;
  localparam logic [OP_W-1:0] OP_LAP   = 4'd10;
  localparam logic [OP_W-1:0] OP_MUL1  = 4'd11;
  localparam logic [OP_W-1:0] OP_SUM   = 4'd12;
  localparam logic [OP_W-1:0] OP_MUL2  = 4'd13;
  localparam logic [OP_W-1:0] OP_WB    = 4'd14;
  localparam logic [OP_W-1:0] OP_FLIP  = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic              out_ld;
  } wdg_cmd_t;

endpackage

// File: design/wdg_ifs.sv
// Handshake channel interfaces: request in, result out, register write.
`timescale 1ns / 1ps
interface wdg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] value;
  modport source(output valid, action, row, col, value, input ready);
  modport sink(input valid, action, row, col, value, output ready);
endinterface

interface wdg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_value;
  logic               saturated;
  modport source(output valid, cell_value, saturated, input ready);
  modport sink(input valid, cell_value, saturated, output ready);
endinterface

interface wdg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/wdg_ctrl.sv
// Controller: clearing pass, request sequencing and the per-cell step sweep.
`timescale 1ns / 1ps
module wdg_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [1:0]                    in_action,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output wdg_pkg::wdg_cmd_t             cmd
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_EXEC = 4'd3;
  localparam logic [3:0] ST_OUT  = 4'd4;
  localparam logic [3:0] ST_C    = 4'd5;
  localparam logic [3:0] ST_N    = 4'd6;
  localparam logic [3:0] ST_S    = 4'd7;
  localparam logic [3:0] ST_W    = 4'd8;
  localparam logic [3:0] ST_E    = 4'd9;
  localparam logic [3:0] ST_LAP  = 4'd10;
  localparam logic [3:0] ST_MUL1 = 4'd11;
  localparam logic [3:0] ST_SUM  = 4'd12;
  localparam logic [3:0] ST_MUL2 = 4'd13;
  localparam logic [3:0] ST_WB   = 4'd14;
  localparam logic [3:0] ST_FLIP = 4'd15;

  localparam logic [wdg_pkg::IDX_W-1:0] LAST_IDX = wdg_pkg::IDX_W'(wdg_pkg::GRID_SIZE - 1);

  logic [3:0]                state_r, state_nxt;
  logic [wdg_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [wdg_pkg::IDX_W-1:0] up, dn, lf, rt;
  logic                      last;

  // torus neighbors
  assign up   = (i_r == '0) ? LAST_IDX : i_r - 1'b1;
  assign dn   = (i_r == LAST_IDX) ? '0 : i_r + 1'b1;
  assign lf   = (j_r == '0) ? LAST_IDX : j_r - 1'b1;
  assign rt   = (j_r == LAST_IDX) ? '0 : j_r + 1'b1;
  assign last = (i_r == LAST_IDX) && (j_r == LAST_IDX);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = wdg_pkg::OP_IDLE;
    cmd.addr      = {i_r, j_r};
    cmd.out_ld    = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.op = wdg_pkg::OP_CLEAR;
        j_nxt  = rt;
        if (j_r == LAST_IDX) i_nxt = dn;
        if (last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = wdg_pkg::OP_LOAD;
          if (in_action == wdg_pkg::ACT_STEP) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_C;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.op    = wdg_pkg::OP_RD;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.op    = wdg_pkg::OP_EXEC;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_C: begin
        cmd.op    = wdg_pkg::OP_C;
        state_nxt = ST_N;
      end
      ST_N: begin
        cmd.op    = wdg_pkg::OP_N;
        cmd.addr  = {up, j_r};
        state_nxt = ST_S;
      end
      ST_S: begin
        cmd.op    = wdg_pkg::OP_S;
        cmd.addr  = {dn, j_r};
        state_nxt = ST_W;
      end
      ST_W: begin
        cmd.op    = wdg_pkg::OP_WEST;
        cmd.addr  = {i_r, lf};
        state_nxt = ST_E;
      end
      ST_E: begin
        cmd.op    = wdg_pkg::OP_EAST;
        cmd.addr  = {i_r, rt};
        state_nxt = ST_LAP;
      end
      ST_LAP: begin
        cmd.op    = wdg_pkg::OP_LAP;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op    = wdg_pkg::OP_MUL1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = wdg_pkg::OP_SUM;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = wdg_pkg::OP_MUL2;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.op = wdg_pkg::OP_WB;
        j_nxt  = rt;
        if (j_r == LAST_IDX) i_nxt = dn;
        state_nxt = last ? ST_FLIP : ST_C;
      end
      ST_FLIP: begin
        cmd.op    = wdg_pkg::OP_FLIP;
        state_nxt = ST_OUT;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/wdg_dp.sv
// Datapath: both grid memories, registers, stencil arithmetic and result register.
`timescale 1ns / 1ps
module wdg_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wdg_pkg::wdg_cmd_t                cmd,
  input  logic                             cfg_we,
  input  logic [wdg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wdg_pkg::REG_W-1:0]        cfg_data,
  input  logic [1:0]                       in_action,
  input  logic [5:0]                       in_row,
  input  logic [5:0]                       in_col,
  input  logic signed [31:0]               in_value,
  output logic signed [31:0]               out_cell_value,
  output logic                             out_saturated
);

  localparam int CELLS = wdg_pkg::GRID_SIZE * wdg_pkg::GRID_SIZE;
  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  logic [wdg_pkg::DATA_W-1:0] mem0 [CELLS];
  logic [wdg_pkg::DATA_W-1:0] mem1 [CELLS];

  logic [wdg_pkg::REG_W-1:0]  gain_r, damp_r;
  logic                       sel_r;
  logic [1:0]                 act_r;
  logic [wdg_pkg::ADDR_W-1:0] addr_r;
  logic signed [31:0]         val_r;
  logic signed [31:0]         d0_r, d1_r;
  logic signed [31:0]         c_r, p_r;
  logic signed [33:0]         acc_r;
  logic signed [35:0]         lap_r;
  logic signed [53:0]         p1_r;
  logic signed [37:0]         s_r;
  logic signed [55:0]         p2_r;
  logic signed [31:0]         res_r, out_val_r;
  logic                       sat_r, out_sat_r;

  logic [wdg_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic signed [31:0]         cur_d, prv_d, wr_data;
  logic                       we_cur, we_prv, we0, we1;
  logic signed [32:0]         sum33;
  logic                       add_ovf;
  logic signed [31:0]         exec_val;
  logic                       exec_sat;
  logic signed [17:0]         gain_s, damp_s;
  logic signed [53:0]         p1_rnd;
  logic signed [55:0]         p2_rnd;
  logic signed [39:0]         n40;
  logic                       n_ovf;
  logic signed [31:0]         n_val;

  assign cur_d  = sel_r ? d1_r : d0_r;
  assign prv_d  = sel_r ? d0_r : d1_r;
  assign gain_s = $signed({1'b0, gain_r});
  assign damp_s = $signed({1'b0, damp_r});

  assign rd_addr = (cmd.op == wdg_pkg::OP_RD) ? addr_r : cmd.addr;

  // single-cell requests
  assign sum33   = {cur_d[31], cur_d} + {val_r[31], val_r};
  assign add_ovf = sum33[32] != sum33[31];
  always_comb begin
    exec_sat = 1'b0;
    case (act_r)
      wdg_pkg::ACT_WRITE: exec_val = val_r;
      wdg_pkg::ACT_ADD: begin
        exec_val = add_ovf ? (sum33[32] ? MIN32 : MAX32) : sum33[31:0];
        exec_sat = add_ovf;
      end
      default: exec_val = cur_d;
    endcase
  end

  // rounding to nearest, ties up, then clip of the new cell
  assign p1_rnd = p1_r + 54'sd32768;
  assign p2_rnd = p2_r + 56'sd32768;
  assign n40    = p2_rnd[55:16];
  assign n_ovf  = !((&n40[39:31]) || !(|n40[39:31]));
  assign n_val  = n_ovf ? (n40[39] ? MIN32 : MAX32) : n40[31:0];

  always_comb begin
    we_cur  = 1'b0;
    we_prv  = 1'b0;
    wr_addr = cmd.addr;
    wr_data = n_val;
    case (cmd.op)
      wdg_pkg::OP_CLEAR: begin
        we_cur  = 1'b1;
        we_prv  = 1'b1;
        wr_data = '0;
      end
      wdg_pkg::OP_EXEC: begin
        we_cur  = (act_r == wdg_pkg::ACT_WRITE) || (act_r == wdg_pkg::ACT_ADD);
        wr_addr = addr_r;
        wr_data = exec_val;
      end
      wdg_pkg::OP_WB: we_prv = 1'b1;
      default: ;
    endcase
  end

  assign we0 = sel_r ? we_prv : we_cur;
  assign we1 = sel_r ? we_cur : we_prv;

  always_ff @(posedge clk) begin
    if (we0) mem0[wr_addr] <= wr_data;
    if (we1) mem1[wr_addr] <= wr_data;
    d0_r <= mem0[rd_addr];
    d1_r <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= wdg_pkg::GAIN_RESET;
      damp_r <= wdg_pkg::DAMP_RESET;
      sel_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == wdg_pkg::REG_GAIN) gain_r <= cfg_data;
      if (cfg_we && cfg_index == wdg_pkg::REG_DAMP) damp_r <= cfg_data;
      if (cmd.op == wdg_pkg::OP_FLIP) sel_r <= !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      wdg_pkg::OP_LOAD: begin
        act_r  <= in_action;
        addr_r <= {in_row[wdg_pkg::IDX_W-1:0], in_col[wdg_pkg::IDX_W-1:0]};
        val_r  <= in_value;
        sat_r  <= 1'b0;
      end
      wdg_pkg::OP_EXEC: begin
        res_r <= exec_val;
        sat_r <= exec_sat;
      end
      wdg_pkg::OP_N: begin
        c_r <= cur_d;
        p_r <= prv_d;
      end
      wdg_pkg::OP_S:    acc_r <= 34'(cur_d);
      wdg_pkg::OP_WEST: acc_r <= acc_r + 34'(cur_d);
      wdg_pkg::OP_EAST: acc_r <= acc_r + 34'(cur_d);
      wdg_pkg::OP_LAP:  lap_r <= 36'(acc_r) + 36'(cur_d) - (36'(c_r) <<< 2);
      wdg_pkg::OP_MUL1: p1_r  <= lap_r * gain_s;
      wdg_pkg::OP_SUM:  s_r   <= p1_rnd[53:16] + (38'(c_r) <<< 1) - 38'(p_r);
      wdg_pkg::OP_MUL2: p2_r  <= s_r * damp_s;
      wdg_pkg::OP_WB:   sat_r <= sat_r | n_ovf;
      wdg_pkg::OP_FLIP: res_r <= '0;
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_val_r <= res_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_cell_value = out_val_r;
  assign out_saturated  = out_sat_r;

endmodule

// File: design/damped_wave_grid_step.sv
// Top level of the damped 2-D wave grid: controller, datapath and assertions.
`timescale 1ns / 1ps
// Keeps a 64x64 toroidal grid of Q16.16 displacements (current and previous)
// in two 4096-word memories. After reset the block runs a clearing pass
// that zeroes both memories; in_ch.ready stays low during it, while
// register writes are taken at once (cfg_ch.ready is always high). A
// write, add or read request passes from acceptance through a read state
// and an execute state to the result register. A step request walks the
// grid one cell at a time: five reads from the single read port of the
// current grid, two multiplies by the Q1.16 gain and damping, and the
// write-back into the previous grid's memory, which then becomes the
// current one. One request is in work at a time; a new one is
// accepted while the previous result still waits in the output register.
module damped_wave_grid_step (
  input logic       clk,
  input logic       rst_n,
  wdg_in_if.sink    in_ch,
  wdg_out_if.source out_ch,
  wdg_cfg_if.sink   cfg_ch
);

  wdg_pkg::wdg_cmd_t cmd;

  // register writes are always taken; the user must send them only while idle, the block does not enforce this
  assign cfg_ch.ready = 1'b1;

  wdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  wdg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .in_action      (in_ch.action),
    .in_row         (in_ch.row),
    .in_col         (in_ch.col),
    .in_value       (in_ch.value),
    .out_cell_value (out_ch.cell_value),
    .out_saturated  (out_ch.saturated)
  );

  // no request is taken in the first cycle of the clearing pass
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_ch.ready)
    else $error("request accepted during clearing pass");

  // an accepted request always leaves idle, so the following cycle takes no request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second request accepted back to back");

  // the datapath sees a load command exactly when a request is accepted
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == wdg_pkg::OP_LOAD) == (in_ch.valid && in_ch.ready))
    else $error("load command out of step with request acceptance");

endmodule
